/* rtl/srsort_pkg.sv */
// shared types and constants of the strip record insertion sorter
`default_nettype none

package srsort_pkg;

	localparam int CAPACITY_DEF = 32;

	localparam int NUM_W = 10;
	localparam int VAL_W = 12;
	localparam int HELD_W = 6;

	// item kind codes
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TAKE = 1'b1;

	typedef struct packed {
		logic [NUM_W-1:0] strip_number;
		logic [VAL_W-1:0] adc_signal;
		logic [VAL_W-1:0] noise_sigma;
	} rec_t;

	typedef struct packed {
		logic             kind;
		logic [NUM_W-1:0] strip_number;
		logic [VAL_W-1:0] adc_signal;
		logic [VAL_W-1:0] noise_sigma;
	} in_item_t;

	typedef struct packed {
		logic              accepted;
		logic              store_full;
		logic              store_empty;
		logic [NUM_W-1:0]  out_strip_number;
		logic [VAL_W-1:0]  out_adc_signal;
		logic [VAL_W-1:0]  out_noise_sigma;
		logic [HELD_W-1:0] held_count;
	} out_item_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;
		logic take;
		rec_t rec;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/srsort_chan_if.sv */
// valid/ready channel carrying one payload beat
`default_nettype none

interface srsort_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/srsort_cell.sv */
// one cell of the sorting chain: holds a record, shifts right on insert, left on take
`default_nettype none

module srsort_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 6
) (
	input  wire              clk,
	input  srsort_pkg::cmd_t cmd,
	input  wire [CNT_W-1:0]  count,
	input  wire              left_stay,
	input  srsort_pkg::rec_t left_rec,
	input  srsort_pkg::rec_t right_rec,
	output logic             stay,
	output srsort_pkg::rec_t rec
);
	import srsort_pkg::*;

	rec_t rec_q;
	logic occupied;

	// a held record with key not above the new one keeps its place
	always_comb begin
		occupied = count > CNT_W'(IDX);
		stay     = occupied && (rec_q.strip_number <= cmd.rec.strip_number);
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!stay) begin
				rec_q <= left_stay ? cmd.rec : left_rec;
			end
		end else if (cmd.take) begin
			rec_q <= right_rec;
		end
	end

	assign rec = rec_q;

endmodule

`default_nettype wire

/* rtl/strip_record_insertion_sorter_top.sv */
// top level of the strip record insertion sorter: cell chain, count and result register
`default_nettype none

// Keeps up to CAPACITY strip records sorted by strip number, oldest first among
// equal numbers, in a row of cells. An add beat drops the record into place in a
// single compare-and-shift step: every cell compares its own key with the new one
// and either keeps its record, takes the new one, or takes its left neighbor's. A
// take beat shifts the whole row left by one and returns the head record. Each
// input beat gives one result beat, registered and shown the cycle after the input
// is taken; the sorter takes one beat per clock as long as results are drained.
// A strip number of zero is refused, an add to a full store sets store_full and a
// take from an empty store sets store_empty. No clearing pass after reset.
module strip_record_insertion_sorter_top #(
	parameter int CAPACITY = srsort_pkg::CAPACITY_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	srsort_chan_if.sink   items,
	srsort_chan_if.source results
);
	import srsort_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// chain wiring
	logic [CAPACITY-1:0] stay;
	rec_t                cell_rec [CAPACITY];

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             out_valid_q;
	out_item_t        out_q;

	in_item_t  item;
	logic      accept;
	logic      is_full;
	logic      is_empty;
	cmd_t      cmd;
	out_item_t res;
	logic [CNT_W+HELD_W-1:0] held_wide;

	assign item = items.payload;

	// the result register frees up as soon as the sink takes its beat
	assign items.ready = !out_valid_q || results.ready;
	assign accept      = items.valid && items.ready;

	assign is_full  = count_q >= CNT_W'(CAPACITY);
	assign is_empty = count_q == '0;

	always_comb begin
		cmd.ins  = accept && (item.kind == KIND_ADD) && (item.strip_number != '0) && !is_full;
		cmd.take = accept && (item.kind == KIND_TAKE) && !is_empty;
		cmd.rec.strip_number = item.strip_number;
		cmd.rec.adc_signal   = item.adc_signal;
		cmd.rec.noise_sigma  = item.noise_sigma;
	end

	always_comb begin
		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (cmd.take) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// held count shown masked to six bits
	assign held_wide = {{HELD_W{1'b0}}, count_next};

	always_comb begin
		res = '0;
		res.held_count = held_wide[HELD_W-1:0];
		if (item.kind == KIND_ADD) begin
			res.accepted   = cmd.ins;
			// a zero strip number is refused before the full check
			res.store_full = (item.strip_number != '0) && is_full;
		end else begin
			res.accepted    = !is_empty;
			res.store_empty = is_empty;
			if (!is_empty) begin
				res.out_strip_number = cell_rec[0].strip_number;
				res.out_adc_signal   = cell_rec[0].adc_signal;
				res.out_noise_sigma  = cell_rec[0].noise_sigma;
			end
		end
	end

	// the row of cells; the head sees a keeping neighbor, the tail keeps its own on take
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		srsort_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.left_stay ((i == 0) ? 1'b1 : stay[(i == 0) ? 0 : i-1]),
			.left_rec  (cell_rec[(i == 0) ? 0 : i-1]),
			.right_rec (cell_rec[(i == CAPACITY-1) ? i : i+1]),
			.stay      (stay[i]),
			.rec       (cell_rec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	// the count never runs past the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("record count above capacity");

	// a stored add grows the count by exactly one
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not bump count");

	// at most one outcome flag per result beat
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> $onehot0({results.payload.accepted, results.payload.store_full,
			results.payload.store_empty}))
		else $error("conflicting result flags");

	// the two head cells stay in order
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |->
			(cell_rec[0].strip_number <= cell_rec[1].strip_number))
		else $error("head cells out of order");

endmodule

`default_nettype wire
